/* rtl/assert_macros.svh */
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mtpn_pkg.sv */
// Types and constants of the multi-track mixer with peak normalization.
package mtpn_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int SUM_W            = 18;
  localparam int TRACKS           = 4;
  localparam int ACT_W            = 3;
  localparam int FS_SHIFT         = 15;     // 32767 = 2^15 - 1
  localparam int Q_W              = 15;     // quotient never reaches 2^15
  localparam int PROD_W           = SUM_W + FS_SHIFT;
  localparam int BUFFER_DEPTH_DEF = 4096;
  localparam logic [SUM_W-1:0] FULL_SCALE = SUM_W'(32767);
  localparam logic [ACT_W-1:0] ACT_RESET  = ACT_W'(4);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic                       start_new;
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       last_sample;
    logic                       sample_valid;
    logic                       was_scaled;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/mtpn_store.sv */
// Sum buffer: one write port, one registered read port.
module mtpn_store #(
  parameter int DEPTH = mtpn_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mtpn_pkg::SUM_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [mtpn_pkg::SUM_W-1:0] rd_data
);

  logic [mtpn_pkg::SUM_W-1:0] mem [DEPTH];
  logic [mtpn_pkg::SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/mtpn_serial_div.sv */
// Bit-serial restoring divider: floor(mag * 32767 / divisor), one quotient bit a cycle.
`include "assert_macros.svh"

module mtpn_serial_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mtpn_pkg::div_req_t req,
  output mtpn_pkg::div_rsp_t rsp
);

  localparam int SUM_W = mtpn_pkg::SUM_W;
  localparam int Q_W   = mtpn_pkg::Q_W;
  localparam int CW    = $clog2(Q_W + 1);

  logic [SUM_W-1:0]                 rem_r, rem_nxt;
  logic [Q_W-1:0]                   lo_r, lo_nxt;
  logic [Q_W-1:0]                   quot_r, quot_nxt;
  logic [SUM_W-1:0]                 div_r, div_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [mtpn_pkg::PROD_W-1:0]      prod;
  logic [SUM_W:0]                   trial;
  logic [SUM_W:0]                   diff;

  // mag * 32767 as (mag << 15) - mag
  assign prod  = {req.mag, Q_W'(0)} - mtpn_pkg::PROD_W'(req.mag);
  assign trial = {rem_r, lo_r[Q_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quot_nxt = quot_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = prod[mtpn_pkg::PROD_W-1:Q_W];
      lo_nxt   = prod[Q_W-1:0];
      quot_nxt = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = CW'(Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[SUM_W]) begin
        rem_nxt  = diff[SUM_W-1:0];
        quot_nxt = {quot_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[SUM_W-1:0];
        quot_nxt = {quot_r[Q_W-2:0], 1'b0};
      end
      lo_nxt  = {lo_r[Q_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    quot_r <= quot_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  `ASSERT_IMPL(a_no_restart, clk, rst_n, req.start, !busy_r, "divider restarted while busy")
  `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r && !busy_r, "done held or busy after done")

endmodule

/* rtl/multi_track_mix_peak_normalize.sv */
// Top level of the multi-track mixer with peak normalization.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data        | valid/ready, taken when both
//  result  | out_valid, out_ready, out_data     | valid/ready, taken when both
//  config  | cfg_wr_en, cfg_wr_data             | write on enable, no wait
//
//  Loads stay in idle and can follow each other every cycle while no read is in
//  flight. A read passes accept, buffer read and hand-off when unscaled, and when
//  the peak exceeds 32767: accept, buffer read with divider start, the quotient
//  steps and the done pulse of the bit-serial divider, hand-off.
//  Synchronous active-low reset; the sum buffer holds no reset and needs no clear.
//  in_ready is low while a read is in flight; a read holds in hand-off while the
//  previous result still waits in the output register for out_ready.
`include "assert_macros.svh"

module multi_track_mix_peak_normalize #(
  parameter int BUFFER_DEPTH = mtpn_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mtpn_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mtpn_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [mtpn_pkg::ACT_W-1:0]       cfg_wr_data
);

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W = mtpn_pkg::SUM_W;
  localparam int SW    = mtpn_pkg::SAMPLE_W;
  localparam int ACT_W = mtpn_pkg::ACT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ACT_W-1:0]       act_r, act_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [SUM_W-1:0]       peak_r, peak_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mtpn_pkg::out_item_t    out_r, out_nxt;
  mtpn_pkg::out_item_t    pend_r, pend_nxt;
  logic                   rdv_r, rdv_nxt;     // read hits a stored sum
  logic                   rdl_r, rdl_nxt;     // read hits the last stored sum
  logic                   neg_r, neg_nxt;     // sign of the sum being scaled

  logic [CNT_W-1:0]       cnt_eff;
  logic [SUM_W-1:0]       peak_eff;
  logic [ACT_W-1:0]       trk_n;
  logic signed [SW-1:0]   samp [mtpn_pkg::TRACKS];
  logic signed [SUM_W-1:0] mix_sum;
  logic [SUM_W-1:0]       mix_mag;
  logic [SUM_W-1:0]       rd_sum;
  logic [SUM_W-1:0]       rd_mag;
  logic [SW-1:0]          q_ext;
  logic                   out_scaled;

  logic                   wr_en;
  logic                   rd_en;
  mtpn_pkg::div_req_t     div_req;
  mtpn_pkg::div_rsp_t     div_rsp;

  // Active track count, saturated to the number of sample fields.
  assign trk_n = (act_r > ACT_W'(mtpn_pkg::TRACKS)) ? ACT_W'(mtpn_pkg::TRACKS) : act_r;

  assign samp[0] = in_data.sample_0;
  assign samp[1] = in_data.sample_1;
  assign samp[2] = in_data.sample_2;
  assign samp[3] = in_data.sample_3;

  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < mtpn_pkg::TRACKS; i++) begin
      if (ACT_W'(i) < trk_n) begin
        mix_sum = mix_sum + SUM_W'(samp[i]);
      end
    end
  end

  assign mix_mag = mix_sum[SUM_W-1] ? SUM_W'(-mix_sum) : SUM_W'(mix_sum);
  assign rd_mag  = rd_sum[SUM_W-1]  ? SUM_W'(-rd_sum)  : rd_sum;
  assign q_ext   = {1'b0, div_rsp.quot};

  // start_new clears count, peak and read position before the load lands
  assign cnt_eff  = in_data.start_new ? '0 : cnt_r;
  assign peak_eff = in_data.start_new ? '0 : peak_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    peak_nxt      = peak_r;
    rdv_nxt       = rdv_r;
    rdl_nxt       = rdl_r;
    neg_nxt       = neg_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    div_req       = '0;
    div_req.mag     = rd_mag;
    div_req.divisor = peak_r;

    if (cfg_wr_en) begin
      act_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == mtpn_pkg::REQ_LOAD) begin
            cnt_nxt  = cnt_eff;
            peak_nxt = peak_eff;
            if (in_data.start_new) begin
              pos_nxt = '0;
            end
            // a load into a full buffer is dropped
            if (cnt_eff < CNT_W'(BUFFER_DEPTH)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_eff + CNT_W'(1);
              if (mix_mag > peak_eff) begin
                peak_nxt = mix_mag;
              end
            end
          end else begin
            rd_en   = 1'b1;
            rdv_nxt = (pos_r < cnt_r);
            rdl_nxt = ((pos_r + CNT_W'(1)) == cnt_r);
            if (pos_r < cnt_r) begin
              pos_nxt = pos_r + CNT_W'(1);
            end
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // buffer data is valid this cycle
        neg_nxt = rd_sum[SUM_W-1];
        if (!rdv_r) begin
          pend_nxt  = '0;
          state_nxt = S_DONE;
        end else if (peak_r > mtpn_pkg::FULL_SCALE) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          pend_nxt.mixed_sample = rd_sum[SW-1:0];
          pend_nxt.last_sample  = rdl_r;
          pend_nxt.sample_valid = 1'b1;
          pend_nxt.was_scaled   = 1'b0;
          state_nxt             = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pend_nxt.mixed_sample = neg_r ? -q_ext : q_ext;
          pend_nxt.last_sample  = rdl_r;
          pend_nxt.sample_valid = 1'b1;
          pend_nxt.was_scaled   = 1'b1;
          state_nxt             = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= mtpn_pkg::ACT_RESET;
      cnt_r       <= '0;
      pos_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdv_r  <= rdv_nxt;
    rdl_r  <= rdl_nxt;
    neg_r  <= neg_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_scaled = out_valid_r && out_r.was_scaled;

  mtpn_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_eff[AW-1:0]),
    .wr_data (mix_sum),
    .rd_en   (rd_en),
    .rd_addr (pos_r[AW-1:0]),
    .rd_data (rd_sum)
  );

  mtpn_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(BUFFER_DEPTH), "count past depth")
  `ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_r <= cnt_r, "read position past count")
  `ASSERT_IMPL(a_scaled_ok, clk, rst_n, out_scaled, out_r.sample_valid, "scaled but invalid")
  `ASSERT_IMPL(a_ready_free, clk, rst_n, in_ready, !div_rsp.busy, "input taken while divider busy")

endmodule
